[sv/kt_pkg.sv]
`timescale 1ns / 1ps
// Package for the keyed table: sizes, action and status codes, payload types.
// No dependencies; every other file of the block depends on it.
package kt_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_DUP    = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        t_action                 action;
        logic [KEY_BITS-1:0]     key;
        logic [VALUE_BITS-1:0]   value;
    } t_req;

    typedef struct packed {
        logic                    found;
        logic [VALUE_BITS-1:0]   read_value;
        t_status                 status;
        logic [CNT_BITS-1:0]     entry_count;
        logic                    is_empty;
        logic                    is_full;
    } t_rsp;

    // Broadcast from the controller to every cell of the chain
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic [KEY_BITS-1:0]     key;
        logic [VALUE_BITS-1:0]   value;
    } t_cell_ctl;

endpackage

[sv/kt_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the keyed table: valid/ready handshake with a request payload.
// Depends on kt_pkg.
interface kt_req_if;
    logic          valid;
    logic          ready;
    kt_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/kt_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel of the keyed table: valid/ready handshake with a result payload.
// Depends on kt_pkg.
interface kt_rsp_if;
    logic          valid;
    logic          ready;
    kt_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/kt_cell.sv]
`timescale 1ns / 1ps
// One slot of the table: holds a key/value pair, compares against the request key,
// loads the request pair on insert at the fill point, and on delete takes its upper neighbor's pair. Depends on kt_pkg.
module kt_cell (
    input  logic                          i_clk,
    input  kt_pkg::t_cell_ctl             i_ctl,
    input  logic                          i_live,
    input  logic                          i_ins_here,
    input  logic                          i_shift_in,
    input  logic [kt_pkg::VALUE_BITS-1:0] i_rd_in,
    input  logic [kt_pkg::KEY_BITS-1:0]   i_next_key,
    input  logic [kt_pkg::VALUE_BITS-1:0] i_next_value,
    output logic                          o_shift_out,
    output logic [kt_pkg::VALUE_BITS-1:0] o_rd_out,
    output logic [kt_pkg::KEY_BITS-1:0]   o_key,
    output logic [kt_pkg::VALUE_BITS-1:0] o_value
);
    import kt_pkg::*;

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  w_match;

    // Compare only occupied slots; keys are unique so at most one cell matches
    assign w_match     = i_live && (r_key == i_ctl.key);
    assign o_shift_out = i_shift_in || w_match;
    assign o_rd_out    = i_rd_in | (w_match ? r_value : '0);
    assign o_key       = r_key;
    assign o_value     = r_value;

    // Shift down at and above the deleted slot; append at the fill point
    always_ff @(posedge i_clk) begin
        if (i_ctl.del && (i_shift_in || w_match)) begin
            r_key   <= i_next_key;
            r_value <= i_next_value;
        end else if (i_ctl.ins && i_ins_here) begin
            r_key   <= i_ctl.key;
            r_value <= i_ctl.value;
        end
    end

endmodule

[sv/keyed_table_with_compaction_unit.sv]
`timescale 1ns / 1ps
// Keyed table top level: request register, chain of slot cells, count and result register.
// Depends on kt_pkg, kt_req_if, kt_rsp_if and kt_cell.
//
//   Port    Direction  Handshake     Payload
//   i_req   in         valid/ready   action, key, value
//   o_rsp   out        valid/ready   found, read_value, status, entry_count, is_empty, is_full
//
// An item is first held in the request register; when the result register can take it,
// the cell chain compares the key in every slot, ripples match and read data through the
// chain, and updates slots, count and the result register. One request is in flight at a time.
// Reset (synchronous, active low) empties the table; slot contents are not cleared.
// A result waiting on o_rsp does not block the next request from being registered.
module keyed_table_with_compaction_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    kt_req_if.sink   i_req,
    kt_rsp_if.source o_rsp
);
    import kt_pkg::*;

    logic                  r_busy;
    t_req                  r_req;
    logic [CNT_BITS-1:0]   r_count;
    logic                  r_out_valid;
    t_rsp                  r_rsp;

    logic [CNT_BITS-1:0]   n_count;
    t_rsp                  n_rsp;
    logic                  w_exec;
    logic                  w_found;
    logic                  w_full;
    t_cell_ctl             w_ctl;

    logic                  w_shift [0:CAPACITY];
    logic [VALUE_BITS-1:0] w_rd    [0:CAPACITY];
    logic [KEY_BITS-1:0]   w_key   [0:CAPACITY-1];
    logic [VALUE_BITS-1:0] w_val   [0:CAPACITY-1];

    assign i_req.ready = !r_busy;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // Execute when a request is held and the result register can take it
    assign w_exec  = r_busy && (!r_out_valid || o_rsp.ready);
    assign w_found = w_shift[CAPACITY];
    assign w_full  = (r_count == CNT_BITS'(CAPACITY));

    assign w_ctl.ins   = w_exec && (r_req.action == ACT_INSERT) && !w_found && !w_full;
    assign w_ctl.del   = w_exec && (r_req.action == ACT_DELETE);
    assign w_ctl.key   = r_req.key;
    assign w_ctl.value = r_req.value;

    assign w_shift[0] = 1'b0;
    assign w_rd[0]    = '0;

    // Build the chain; the top slot refills from itself on delete
    generate
        for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [KEY_BITS-1:0]   w_nkey;
            logic [VALUE_BITS-1:0] w_nval;
            if (gi < CAPACITY - 1) begin : g_mid
                assign w_nkey = w_key[gi+1];
                assign w_nval = w_val[gi+1];
            end else begin : g_top
                assign w_nkey = w_key[gi];
                assign w_nval = w_val[gi];
            end
            kt_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_live       (CNT_BITS'(gi) < r_count),
                .i_ins_here   (CNT_BITS'(gi) == r_count),
                .i_shift_in   (w_shift[gi]),
                .i_rd_in      (w_rd[gi]),
                .i_next_key   (w_nkey),
                .i_next_value (w_nval),
                .o_shift_out  (w_shift[gi+1]),
                .o_rd_out     (w_rd[gi+1]),
                .o_key        (w_key[gi]),
                .o_value      (w_val[gi])
            );
        end
    endgenerate

    // Decide status, new count and result fields
    always_comb begin
        n_count          = r_count;
        n_rsp.found      = w_found;
        n_rsp.read_value = '0;
        n_rsp.status     = ST_DONE;
        case (r_req.action)
            ACT_LOOKUP: begin
                n_rsp.read_value = w_rd[CAPACITY];
            end
            ACT_INSERT: begin
                if (w_found) begin
                    n_rsp.status = ST_DUP;
                end else if (w_full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_BITS'(1);
                end
            end
            ACT_DELETE: begin
                if (!w_found) begin
                    n_rsp.status = ST_ABSENT;
                end else begin
                    n_count = r_count - CNT_BITS'(1);
                end
            end
            ACT_CLEAR: begin
                n_count     = '0;
                n_rsp.found = 1'b0;
            end
            default: begin
                n_rsp.found = 1'b0;
            end
        endcase
        n_rsp.entry_count = n_count;
        n_rsp.is_empty    = (n_count == '0);
        n_rsp.is_full     = (n_count == CNT_BITS'(CAPACITY));
    end

    // Hold request, count and result; advance on transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.valid && !r_busy) begin
                r_busy <= 1'b1;
                r_req  <= i_req.data;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
                r_rsp       <= n_rsp;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
